FILE: sv/rid_pkg.sv
// shared codes and controller/datapath interface types for the recycled id allocator
package rid_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DUP       = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic capture;
    logic set_dup;
    logic set_full;
    logic set_exh;
    logic alloc_fresh;
    logic push_start;
    logic pop_start;
    logic rd_parent;
    logic dn_last;
    logic wr_cur;
    logic up_step;
    logic dn_step;
    logic load_out;
  } rid_cmd_t;

  typedef struct packed {
    logic op_free;
    logic is_dup;
    logic is_full;
    logic pool_empty;
    logic exhausted;
    logic count_one;
    logic idx_zero;
    logic up_stop;
    logic dn_stop;
    logic out_free;
  } rid_stat_t;

endpackage

FILE: sv/rid_ctrl.sv
// sequencing state machine for the recycled id allocator
module rid_ctrl
  import rid_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  rid_stat_t stat,
  output rid_cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE, EXEC, UP_RD, UP_CMP, DN_LAST, DN_RD, DN_CMP, FIN
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = EXEC;
        end
      end
      EXEC: begin
        if (stat.op_free) begin
          priority if (stat.is_dup) begin
            cmd.set_dup = 1'b1;
            state_next  = FIN;
          end else if (stat.is_full) begin
            cmd.set_full = 1'b1;
            state_next   = FIN;
          end else begin
            cmd.push_start = 1'b1;
            state_next     = UP_RD;
          end
        end else begin
          priority if (!stat.pool_empty) begin
            cmd.pop_start = 1'b1;
            state_next    = stat.count_one ? FIN : DN_LAST;
          end else if (stat.exhausted) begin
            cmd.set_exh = 1'b1;
            state_next  = FIN;
          end else begin
            cmd.alloc_fresh = 1'b1;
            state_next      = FIN;
          end
        end
      end
      UP_RD: begin
        if (stat.idx_zero) begin
          cmd.wr_cur = 1'b1;
          state_next = FIN;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = UP_CMP;
        end
      end
      UP_CMP: begin
        if (stat.up_stop) begin
          cmd.wr_cur = 1'b1;
          state_next = FIN;
        end else begin
          cmd.up_step = 1'b1;
          state_next  = UP_RD;
        end
      end
      DN_LAST: begin
        cmd.dn_last = 1'b1;
        state_next  = DN_RD;
      end
      DN_RD: begin
        state_next = DN_CMP;
      end
      DN_CMP: begin
        if (stat.dn_stop) begin
          cmd.wr_cur = 1'b1;
          state_next = FIN;
        end else begin
          cmd.dn_step = 1'b1;
          state_next  = DN_RD;
        end
      end
      FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/rid_dp.sv
// heap memory, counters and result registers of the recycled id allocator
module rid_dp
  import rid_pkg::*;
#(
  parameter int ID_WIDTH   = 16,
  parameter int POOL_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        opcode,
  input  logic [15:0] id_in,
  input  rid_cmd_t    cmd,
  output rid_stat_t   stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] id_out,
  output logic        from_pool,
  output logic [1:0]  status
);

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int CH_W  = IDX_W + 2;

  logic [ID_WIDTH-1:0] mem [POOL_DEPTH];

  logic [ID_WIDTH-1:0] rd0, rd1, cur, top, res_id, wd, best, child_val, v;
  logic [IDX_W-1:0]    idx, ra0, ra1, parent, last, m_idx;
  logic [CNT_W-1:0]    count, cnt_m1;
  logic [ID_WIDTH:0]   next_fresh;
  logic                op_r, res_pool, we, l_ok, r_ok, l_sel, r_sel;
  logic [1:0]          res_st;
  logic [CH_W-1:0]     lch, rch, cnt_ext;
  logic [ID_WIDTH+15:0] in_ext, id_ext;

  assign in_ext = {{ID_WIDTH{1'b0}}, id_in};
  assign v      = in_ext[ID_WIDTH-1:0];
  assign id_ext = {16'd0, res_id};

  // heap index arithmetic
  assign lch     = {1'b0, idx, 1'b1};
  assign rch     = lch + CH_W'(1);
  assign cnt_ext = CH_W'(count);
  assign parent  = (idx - IDX_W'(1)) >> 1;
  assign cnt_m1  = count - CNT_W'(1);
  assign last    = cnt_m1[IDX_W-1:0];

  // smallest of hole value and two children
  assign l_ok      = lch < cnt_ext;
  assign r_ok      = rch < cnt_ext;
  assign l_sel     = l_ok && (rd0 < cur);
  assign best      = l_sel ? rd0 : cur;
  assign r_sel     = r_ok && (rd1 < best);
  assign child_val = r_sel ? rd1 : rd0;
  assign m_idx     = r_sel ? rch[IDX_W-1:0] : (l_sel ? lch[IDX_W-1:0] : idx);

  assign ra0 = cmd.pop_start ? last : (cmd.rd_parent ? parent : lch[IDX_W-1:0]);
  assign ra1 = rch[IDX_W-1:0];
  assign we  = cmd.wr_cur | cmd.up_step | cmd.dn_step;
  assign wd  = cmd.wr_cur ? cur : (cmd.up_step ? rd0 : child_val);

  always_comb begin
    stat            = '0;
    stat.op_free    = (op_r == OP_FREE);
    stat.pool_empty = (count == '0);
    stat.is_dup     = (count != '0) && (top == cur);
    stat.is_full    = (count == CNT_W'(POOL_DEPTH));
    stat.exhausted  = next_fresh[ID_WIDTH];
    stat.count_one  = (count == CNT_W'(1));
    stat.idx_zero   = (idx == '0);
    stat.up_stop    = (rd0 <= cur);
    stat.dn_stop    = !l_sel && !r_sel;
    stat.out_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= wd;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (we && (idx == '0)) begin
      top <= wd;
    end
    if (cmd.capture) begin
      op_r     <= opcode;
      cur      <= v;
      res_id   <= '0;
      res_pool <= 1'b0;
      res_st   <= ST_OK;
    end
    if (cmd.set_dup) begin
      res_st <= ST_DUP;
    end
    if (cmd.set_full) begin
      res_st <= ST_FULL;
    end
    if (cmd.set_exh) begin
      res_st <= ST_EXHAUSTED;
    end
    if (cmd.alloc_fresh) begin
      res_id <= next_fresh[ID_WIDTH-1:0];
    end
    if (cmd.pop_start) begin
      res_id   <= top;
      res_pool <= 1'b1;
    end
    if (cmd.push_start) begin
      idx <= count[IDX_W-1:0];
    end
    if (cmd.dn_last) begin
      cur <= rd0;
      idx <= '0;
    end
    if (cmd.up_step) begin
      idx <= parent;
    end
    if (cmd.dn_step) begin
      idx <= m_idx;
    end
    if (cmd.load_out) begin
      id_out    <= id_ext[15:0];
      from_pool <= res_pool;
      status    <= res_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      next_fresh <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.push_start) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop_start) begin
        count <= cnt_m1;
      end
      if (cmd.alloc_fresh) begin
        next_fresh <= next_fresh + (ID_WIDTH+1)'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/recycled_id_allocator.sv
// top level of the recycled id allocator: controller plus datapath
// Usage:
//   Input channel (in_valid / in_stall) carries one request: opcode 0 allocates
//   an id, opcode 1 frees id_in into the recycled pool (binary min-heap).
//   Output channel (out_valid / out_stall) returns one result per request:
//   id_out, from_pool and status (ok, duplicate, pool full, exhausted).
//   Requests are handled one at a time; in_stall is high while one is in work.
//   A free climbs the heap from the new leaf towards the root, and an allocate
//   from a pool holding more than one id sifts the last entry down from the
//   root; other requests do not walk the heap. The heap has one write and two
//   read ports; each level is walked as a read state followed by a compare /
//   write state. The next request can be accepted in the cycle after the
//   previous result is loaded into the output register.
//   A new request is accepted while the previous result waits; if out_stall
//   holds the old result, the next finished result waits inside the block.
//   Reset empties the pool and restarts the fresh counter at zero; heap
//   memory is not cleared, entries are only read after being written.
module recycled_id_allocator
  import rid_pkg::*;
#(
  parameter int ID_WIDTH   = 16,
  parameter int POOL_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [15:0] id_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] id_out,
  output logic        from_pool,
  output logic [1:0]  status
);

  rid_cmd_t  cmd;
  rid_stat_t stat;

  rid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rid_dp #(
    .ID_WIDTH   (ID_WIDTH),
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .opcode    (opcode),
    .id_in     (id_in),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .id_out    (id_out),
    .from_pool (from_pool),
    .status    (status)
  );

endmodule
